// ----- rtl/core/ppmf_pkg.sv -----
package ppmf_pkg;

    localparam logic [7:0] SYNC_MARK = 8'hFF;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] REG_SYNC_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_CHANNEL_MIN     = 3'd1;
    localparam logic [2:0] REG_CHANNEL_MAX     = 3'd2;
    localparam logic [2:0] REG_DEADBAND_TOP    = 3'd3;
    localparam logic [2:0] REG_DEADBAND_BOTTOM = 3'd4;
    localparam logic [2:0] REG_DRIVE_FLOOR     = 3'd5;
    localparam logic [2:0] REG_DRIVE_CEILING   = 3'd6;
    localparam logic [2:0] REG_FAILSAFE_LIMIT  = 3'd7;

    localparam logic [7:0] RST_SYNC_THRESHOLD  = 8'd180;
    localparam logic [7:0] RST_CHANNEL_MIN     = 8'd12;
    localparam logic [7:0] RST_CHANNEL_MAX     = 8'd33;
    localparam logic [7:0] RST_DEADBAND_TOP    = 8'd25;
    localparam logic [7:0] RST_DEADBAND_BOTTOM = 8'd20;
    localparam logic [3:0] RST_DRIVE_FLOOR     = 4'd3;
    localparam logic [3:0] RST_DRIVE_CEILING   = 4'd8;
    localparam logic [2:0] RST_FAILSAFE_LIMIT  = 3'd2;

    typedef struct packed {
        logic [7:0] sync_threshold;
        logic [7:0] channel_min;
        logic [7:0] channel_max;
        logic [7:0] deadband_top;
        logic [7:0] deadband_bottom;
        logic [3:0] drive_floor;
        logic [3:0] drive_ceiling;
        logic [2:0] failsafe_limit;
    } cfg_t;

    typedef struct packed {
        logic [3:0] left_forward;
        logic [3:0] left_reverse;
        logic [3:0] right_forward;
        logic [3:0] right_reverse;
        logic [3:0] bridge_enables;
        logic       frame_accepted;
        logic       failsafe_hit;
    } result_t;

    // Limit to the ceiling first, then raise to the floor: floor wins.
    function automatic logic [3:0] clamp_drive(
        input logic [7:0] excess,
        input logic [3:0] floor_lvl,
        input logic [3:0] ceil_lvl
    );
        logic [7:0] v;
        v = excess;
        if (v > {4'd0, ceil_lvl})
        begin
            v = {4'd0, ceil_lvl};
        end
        if (v < {4'd0, floor_lvl})
        begin
            v = {4'd0, floor_lvl};
        end
        return v[3:0];
    endfunction

endpackage

// ----- rtl/core/ppm_frame_to_motor_drive.sv -----
// PPM frame decoder for a two-motor drive. Each request is a rising edge with
// its measured interval or a timer-overflow tick, and yields exactly one
// result holding the four drive levels, the half-bridge enables and the
// frame/failsafe flags after that request. Requests are taken one per clock
// cycle while the output is not stalled. A result is registered: an accepted
// request lands in the input register and, once the output is free, goes in
// one pass of frame check and drive clamping into the result register.
// While a finished result waits, the request side accepts one more request
// into the input register and then stalls until the result is taken.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while no request is in flight. The overflow count
// saturates at failsafe_limit and is not cleared by later edges.
module ppm_frame_to_motor_drive #(
    parameter int CHANNELS = 3
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       req_valid,
    output logic       req_stall,
    input  logic       req_type,
    input  logic [7:0] pulse_ticks,

    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] left_forward,
    output logic [3:0] left_reverse,
    output logic [3:0] right_forward,
    output logic [3:0] right_reverse,
    output logic [3:0] bridge_enables,
    output logic       frame_accepted,
    output logic       failsafe_hit,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import ppmf_pkg::*;

    cfg_t       cfg;
    result_t    step_result;

    logic       req_valid_reg;
    logic       req_valid_next;
    logic       req_type_reg;
    logic [7:0] pulse_ticks_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    result_t    result_reg;

    logic       req_accept;
    logic       out_free;
    logic       advance;

    assign cfg_ready  = 1'b1;
    assign out_free   = !res_valid_reg || !res_stall;
    assign advance    = req_valid_reg && out_free;
    assign req_stall  = req_valid_reg && !out_free;
    assign req_accept = req_valid && !req_stall;

    ppmf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ppmf_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .req_type    (req_type_reg),
        .pulse_ticks (pulse_ticks_reg),
        .cfg         (cfg),
        .result      (step_result)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the request payload until it passes into the result register.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_type_reg    <= req_type;
            pulse_ticks_reg <= pulse_ticks;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign res_valid      = res_valid_reg;
    assign left_forward   = result_reg.left_forward;
    assign left_reverse   = result_reg.left_reverse;
    assign right_forward  = result_reg.right_forward;
    assign right_reverse  = result_reg.right_reverse;
    assign bridge_enables = result_reg.bridge_enables;
    assign frame_accepted = result_reg.frame_accepted;
    assign failsafe_hit   = result_reg.failsafe_hit;

endmodule

// ----- rtl/core/ppmf_cfg_regs.sv -----
module ppmf_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [7:0]          wr_data,
    output ppmf_pkg::cfg_t      cfg
);
    import ppmf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SYNC_THRESHOLD:  cfg_next.sync_threshold  = wr_data;
                REG_CHANNEL_MIN:     cfg_next.channel_min     = wr_data;
                REG_CHANNEL_MAX:     cfg_next.channel_max     = wr_data;
                REG_DEADBAND_TOP:    cfg_next.deadband_top    = wr_data;
                REG_DEADBAND_BOTTOM: cfg_next.deadband_bottom = wr_data;
                REG_DRIVE_FLOOR:     cfg_next.drive_floor     = wr_data[3:0];
                REG_DRIVE_CEILING:   cfg_next.drive_ceiling   = wr_data[3:0];
                REG_FAILSAFE_LIMIT:  cfg_next.failsafe_limit  = wr_data[2:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_threshold  <= RST_SYNC_THRESHOLD;
            cfg_reg.channel_min     <= RST_CHANNEL_MIN;
            cfg_reg.channel_max     <= RST_CHANNEL_MAX;
            cfg_reg.deadband_top    <= RST_DEADBAND_TOP;
            cfg_reg.deadband_bottom <= RST_DEADBAND_BOTTOM;
            cfg_reg.drive_floor     <= RST_DRIVE_FLOOR;
            cfg_reg.drive_ceiling   <= RST_DRIVE_CEILING;
            cfg_reg.failsafe_limit  <= RST_FAILSAFE_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/ppmf_core.sv -----
module ppmf_core #(
    parameter int CHANNELS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                req_type,
    input  logic [7:0]          pulse_ticks,
    input  ppmf_pkg::cfg_t      cfg,
    output ppmf_pkg::result_t   result
);
    import ppmf_pkg::*;

    localparam int DEPTH     = CHANNELS + 3;
    localparam int LAST_SYNC = CHANNELS + 1;

    logic [7:0] store_reg   [DEPTH];
    logic [7:0] store_shift [DEPTH];
    logic       overflow_seen_reg;
    logic       overflow_seen_next;
    logic [2:0] overflow_count_reg;
    logic [2:0] overflow_count_next;
    logic [3:0] drive_reg  [4];
    logic [3:0] drive_next [4];

    logic [7:0] new_interval;
    logic       check_trigger;
    logic       channels_ok;
    logic       syncs_ok;
    logic       frame_ok;
    logic [3:0] count_inc;
    logic       failsafe;
    logic [3:0] motor_fwd [2];
    logic [3:0] motor_rev [2];
    logic [7:0] chan_val  [2];

    always_comb
    begin
        if (overflow_seen_reg || (pulse_ticks > cfg.sync_threshold))
        begin
            new_interval = SYNC_MARK;
        end
        else
        begin
            new_interval = pulse_ticks;
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            store_shift[i] = store_reg[i + 1];
        end
        store_shift[DEPTH - 1] = new_interval;

        check_trigger = (cfg.channel_min < new_interval) && (new_interval < cfg.channel_max);

        channels_ok = 1'b1;
        for (int i = 1; i < LAST_SYNC; i++)
        begin
            if ((store_shift[i] < cfg.channel_min) || (store_shift[i] > cfg.channel_max))
            begin
                channels_ok = 1'b0;
            end
        end
        syncs_ok = (store_shift[0] == SYNC_MARK) && (store_shift[LAST_SYNC] == SYNC_MARK);
        frame_ok = check_trigger && channels_ok && syncs_ok;

        // Channel one drives the left motor, channel two the right one.
        chan_val[0] = store_shift[1];
        chan_val[1] = store_shift[2];
        for (int m = 0; m < 2; m++)
        begin
            motor_fwd[m] = 4'd0;
            motor_rev[m] = 4'd0;
            if (chan_val[m] > cfg.deadband_top)
            begin
                motor_fwd[m] = clamp_drive(chan_val[m] - cfg.deadband_top,
                                           cfg.drive_floor, cfg.drive_ceiling);
            end
            else if (chan_val[m] < cfg.deadband_bottom)
            begin
                motor_rev[m] = clamp_drive(cfg.deadband_bottom - chan_val[m],
                                           cfg.drive_floor, cfg.drive_ceiling);
            end
        end

        count_inc = {1'b0, overflow_count_reg} + 4'd1;

        overflow_seen_next  = overflow_seen_reg;
        overflow_count_next = overflow_count_reg;
        failsafe            = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            drive_next[k] = drive_reg[k];
        end

        if (req_type == REQ_EDGE)
        begin
            overflow_seen_next = 1'b0;
            if (frame_ok)
            begin
                drive_next[0] = motor_fwd[0];
                drive_next[1] = motor_rev[0];
                drive_next[2] = motor_fwd[1];
                drive_next[3] = motor_rev[1];
            end
        end
        else
        begin
            overflow_seen_next = 1'b1;
            if (count_inc > {1'b0, cfg.failsafe_limit})
            begin
                // Saturate at the limit and drop all drives.
                failsafe            = 1'b1;
                overflow_count_next = cfg.failsafe_limit;
                for (int k = 0; k < 4; k++)
                begin
                    drive_next[k] = 4'd0;
                end
            end
            else
            begin
                overflow_count_next = count_inc[2:0];
            end
        end

        result.left_forward      = drive_next[0];
        result.left_reverse      = drive_next[1];
        result.right_forward     = drive_next[2];
        result.right_reverse     = drive_next[3];
        result.bridge_enables[0] = (drive_next[0] != 4'd0) && (drive_next[1] == 4'd0);
        result.bridge_enables[1] = (drive_next[1] != 4'd0) && (drive_next[0] == 4'd0);
        result.bridge_enables[2] = (drive_next[2] != 4'd0) && (drive_next[3] == 4'd0);
        result.bridge_enables[3] = (drive_next[3] != 4'd0) && (drive_next[2] == 4'd0);
        result.frame_accepted    = (req_type == REQ_EDGE) && frame_ok;
        result.failsafe_hit      = failsafe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= 8'd0;
            end
            for (int k = 0; k < 4; k++)
            begin
                drive_reg[k] <= 4'd0;
            end
            overflow_seen_reg  <= 1'b0;
            overflow_count_reg <= 3'd0;
        end
        else if (advance)
        begin
            if (req_type == REQ_EDGE)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    store_reg[i] <= store_shift[i];
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                drive_reg[k] <= drive_next[k];
            end
            overflow_seen_reg  <= overflow_seen_next;
            overflow_count_reg <= overflow_count_next;
        end
    end

endmodule
